>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checkers. Each one samples on clk and
// is held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed: same-cycle rule");

// Consequent checked in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed: next-cycle rule");

`endif

>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Field widths, operation and status codes and the shared write-port type
// of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int AMT_W  = 9;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 9;

  localparam logic [WORD_W-1:0] NONE_WORD = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_RESIZE     = 3'd6,
    OP_APPEND     = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Write into the entry cell of the ring.
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] data;
  } dq_wr_t;

endpackage

>>> rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels of the deque: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface dq_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [dq_pkg::OP_W-1:0]           operation;
  logic signed [dq_pkg::WORD_W-1:0]  value;
  logic [dq_pkg::AMT_W-1:0]          amount;

  modport source (output valid, operation, value, amount, input ready);
  modport sink   (input valid, operation, value, amount, output ready);
endinterface

interface dq_res_if;
  logic                              valid;
  logic                              ready;
  logic [dq_pkg::ST_W-1:0]           status;
  logic signed [dq_pkg::WORD_W-1:0]  front_value;
  logic signed [dq_pkg::WORD_W-1:0]  back_value;
  logic [dq_pkg::OCC_W-1:0]          occupancy;
  logic                              is_empty;
  logic signed [dq_pkg::WORD_W-1:0]  read_value;

  modport source (output valid, status, front_value, back_value, occupancy, is_empty,
                  read_value, input ready);
  modport sink   (input valid, status, front_value, back_value, occupancy, is_empty,
                  read_value, output ready);
endinterface

>>> rtl/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the rotating ring: takes its neighbor's word every
// cycle, or a new word when loaded.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic                        clk,
  input  logic [dq_pkg::WORD_W-1:0]   shift_in,
  input  dq_pkg::dq_wr_t              wr,
  output logic [dq_pkg::WORD_W-1:0]   q
);

  always_ff @(posedge clk) begin
    q <= wr.load ? wr.data : shift_in;
  end

endmodule

>>> rtl/dq_chain.sv
// ----------------------------------------------------------------------------
// dq_chain
// Ring of DEPTH cells that rotates by one cell each cycle. The last cell's
// word is the tap; it re-enters at the first cell, where writes land.
// ----------------------------------------------------------------------------
module dq_chain #(
  parameter int DEPTH = 256
) (
  input  logic                        clk,
  input  dq_pkg::dq_wr_t              wr,
  output logic [dq_pkg::WORD_W-1:0]   tap
);

  localparam dq_pkg::dq_wr_t NO_WR = '0;

  logic [dq_pkg::WORD_W-1:0] word_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_entry
      dq_cell u_cell (
        .clk      (clk),
        .shift_in (word_q[DEPTH-1]),
        .wr       (wr),
        .q        (word_q[0])
      );
    end else begin : g_body
      dq_cell u_cell (
        .clk      (clk),
        .shift_in (word_q[i-1]),
        .wr       (NO_WR),
        .q        (word_q[i])
      );
    end
  end

  assign tap = word_q[DEPTH-1];

endmodule

>>> rtl/dq_seq.sv
// ----------------------------------------------------------------------------
// dq_seq
// Sequencer: plans each command, sweeps the ring once to apply writes and
// catch front, back and read words, then hands the result to the output.
// ----------------------------------------------------------------------------
module dq_seq #(
  parameter int DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  dq_cmd_if.sink                      cmd,
  dq_res_if.source                    res,
  input  logic [dq_pkg::WORD_W-1:0]   tap,
  output dq_pkg::dq_wr_t              wr
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int EXT_W  = ((CNT_W > dq_pkg::AMT_W) ? CNT_W : dq_pkg::AMT_W) + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [SLOT_W:0]   DEPTH_X   = (SLOT_W + 1)'(DEPTH);
  localparam logic [EXT_W-1:0]  DEPTH_E   = EXT_W'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                      state;
  logic [SLOT_W-1:0]           head, head_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [SLOT_W-1:0]           pos;
  logic [SLOT_W-1:0]           sweep;
  logic                        res_valid;

  logic [CNT_W-1:0]            wr_lo, wr_lo_next;
  logic [CNT_W-1:0]            wr_hi, wr_hi_next;
  logic [dq_pkg::WORD_W-1:0]   fill_word;
  logic                        rd_en, rd_en_next;
  logic [dq_pkg::AMT_W-1:0]    rd_off;
  dq_pkg::status_t             status_q, status_next;
  logic [dq_pkg::WORD_W-1:0]   front_q, back_q, rd_q;

  logic [EXT_W-1:0]            cnt_x, amt_x, target;
  logic                        fill;

  logic [SLOT_W:0]             diff, rel;
  logic [CNT_W-1:0]            off_c;
  logic                        in_scan, hit_wr, hit_front, hit_back, hit_rd;
  logic [dq_pkg::WORD_W-1:0]   word;
  logic                        accept, out_free, load_out;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid & cmd.ready;
  assign out_free  = ~res_valid | res.ready;
  assign load_out  = (state == S_DONE) & out_free;
  assign res.valid = res_valid;

  // Plan for the accepted command: new head and count, the band of offsets
  // (from the new head) that receive the fill word, and status.
  always_comb begin
    cnt_x       = EXT_W'(count);
    amt_x       = EXT_W'(cmd.amount);
    target      = cnt_x;
    fill        = 1'b0;
    head_next   = head;
    count_next  = count;
    wr_lo_next  = '0;
    wr_hi_next  = '0;
    rd_en_next  = 1'b0;
    status_next = dq_pkg::ST_OK;
    case (dq_pkg::op_t'(cmd.operation))
      dq_pkg::OP_PUSH_FRONT: begin
        if (count == FULL_CNT) begin
          status_next = dq_pkg::ST_OVERFLOW;
        end else begin
          head_next  = (head == '0) ? LAST_SLOT : head - SLOT_W'(1);
          count_next = count + CNT_W'(1);
          wr_hi_next = CNT_W'(1);
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        fill   = 1'b1;
        target = cnt_x + EXT_W'(1);
      end
      dq_pkg::OP_POP_FRONT: begin
        if (count == '0) begin
          status_next = dq_pkg::ST_UNDERFLOW;
        end else begin
          head_next  = (head == LAST_SLOT) ? '0 : head + SLOT_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (count == '0) begin
          status_next = dq_pkg::ST_UNDERFLOW;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      dq_pkg::OP_READ: begin
        if (amt_x >= cnt_x) begin
          status_next = dq_pkg::ST_RANGE;
        end else begin
          rd_en_next = 1'b1;
        end
      end
      dq_pkg::OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      dq_pkg::OP_RESIZE: begin
        if (amt_x > cnt_x) begin
          fill   = 1'b1;
          target = amt_x;
        end else begin
          count_next = CNT_W'(cmd.amount);
        end
      end
      dq_pkg::OP_APPEND: begin
        fill   = 1'b1;
        target = cnt_x + amt_x;
      end
      default: begin
      end
    endcase
    if (fill) begin
      wr_lo_next = count;
      if (target > DEPTH_E) begin
        count_next  = FULL_CNT;
        status_next = dq_pkg::ST_OVERFLOW;
      end else begin
        count_next = CNT_W'(target);
      end
      wr_hi_next = count_next;
    end
  end

  // Offset of the slot now at the tap, counted from the head.
  always_comb begin
    diff      = {1'b0, pos} - {1'b0, head};
    rel       = diff[SLOT_W] ? diff + DEPTH_X : diff;
    off_c     = CNT_W'(rel[SLOT_W-1:0]);
    in_scan   = (state == S_SCAN);
    hit_wr    = in_scan & (off_c >= wr_lo) & (off_c < wr_hi);
    word      = hit_wr ? fill_word : tap;
    hit_front = in_scan & (off_c == '0);
    hit_back  = in_scan & (count != '0) & (off_c == count - CNT_W'(1));
    hit_rd    = in_scan & rd_en &
                (EXT_W'(rel[SLOT_W-1:0]) == EXT_W'(rd_off));
    wr.load   = hit_wr;
    wr.data   = fill_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      pos       <= '0;
      sweep     <= '0;
      res_valid <= 1'b0;
    end else begin
      pos <= (pos == LAST_SLOT) ? '0 : pos + SLOT_W'(1);
      case (state)
        S_IDLE: begin
          if (accept) begin
            head  <= head_next;
            count <= count_next;
            sweep <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          sweep <= sweep + SLOT_W'(1);
          if (sweep == LAST_SLOT) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_lo     <= wr_lo_next;
      wr_hi     <= wr_hi_next;
      fill_word <= cmd.value;
      rd_en     <= rd_en_next;
      rd_off    <= cmd.amount;
      status_q  <= status_next;
    end
    if (hit_front) begin
      front_q <= word;
    end
    if (hit_back) begin
      back_q <= word;
    end
    if (hit_rd) begin
      rd_q <= word;
    end
    if (load_out) begin
      res.status      <= status_q;
      res.front_value <= (count == '0) ? dq_pkg::NONE_WORD : front_q;
      res.back_value  <= (count == '0) ? dq_pkg::NONE_WORD : back_q;
      res.occupancy   <= dq_pkg::OCC_W'(count);
      res.is_empty    <= (count == '0);
      res.read_value  <= rd_en ? rd_q : dq_pkg::NONE_WORD;
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// One command at a time: the next command beat is accepted only once the
// previous one has had its full revolution of the cell ring and its result
// has been loaded into the result register.
// Reset (rst, synchronous): queue empty, head at slot 0, no result pending.
//   Stored words are not cleared; they are only read after being written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  dq_cmd_if.sink     cmd,
  dq_res_if.source   res
);

  // Storage is a ring of DEPTH one-word cells that rotates by one cell every
  // cycle, like a drum. Slot numbers are fixed to the words, not to the
  // cells: a position counter in the sequencer tracks which slot is at the
  // tap (the last cell). The deque is the ring-buffer view on top of that:
  // a head slot and a count.
  //
  // Per command:
  //   - the accept cycle settles new head/count, the band of offsets that
  //     take the fill word (push, resize grow, append) and the status;
  //   - the sweep then sees every slot pass the tap exactly once;
  //     fill words are written into the entry cell as their slot goes by,
  //     and the front, back and read words are caught at their offsets;
  //   - once the result register is free, the caught words move into it.
  // Fills therefore cost nothing extra: the whole band is written in the
  // same revolution, one word per cycle.
  //
  // The result register parts the two sides: the next command is taken as
  // soon as the result is loaded, while it may still wait for res.ready.

  logic [dq_pkg::WORD_W-1:0] tap;
  dq_pkg::dq_wr_t            wr;

  dq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk (clk),
    .wr  (wr),
    .tap (tap)
  );

  dq_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .tap (tap),
    .wr  (wr)
  );

endmodule

>>> rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque, bound to every double_ended_queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [dq_pkg::ST_W-1:0]           res_status,
  input logic signed [dq_pkg::WORD_W-1:0]  res_front_value,
  input logic signed [dq_pkg::WORD_W-1:0]  res_back_value,
  input logic [dq_pkg::OCC_W-1:0]          res_occupancy,
  input logic                              res_is_empty,
  input logic signed [dq_pkg::WORD_W-1:0]  res_read_value
);

  // A stalled result beat stays valid and keeps its status, occupancy and read value.
  `DQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_occupancy) && $stable(res_read_value))

  // One command at a time: the port closes right after a command beat.
  `DQ_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready)

  // An empty queue shows no front or back word.
  `DQ_ASSERT_SAME(a_empty_ends, res_valid && res_is_empty, res_occupancy == '0 && res_front_value == dq_pkg::NONE_WORD && res_back_value == dq_pkg::NONE_WORD)

  // Underflow only happens on an empty queue, which stays empty.
  `DQ_ASSERT_SAME(a_underflow_empty, res_valid && res_status == dq_pkg::ST_UNDERFLOW, res_is_empty)

  // A read past the end returns the no-word marker.
  `DQ_ASSERT_SAME(a_range_none, res_valid && res_status == dq_pkg::ST_RANGE, res_read_value == dq_pkg::NONE_WORD)

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_status      (res.status),
  .res_front_value (res.front_value),
  .res_back_value  (res.back_value),
  .res_occupancy   (res.occupancy),
  .res_is_empty    (res.is_empty),
  .res_read_value  (res.read_value)
);

>>> test/double_ended_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Shadow deque driven by accepted command beats; every result beat is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module double_ended_queue_checker #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  dq_cmd_if                        cmd,
  dq_res_if                        res,
  output int                       mismatches,
  output int                       outstanding,
  output logic [dq_pkg::OCC_W-1:0] predicted_count
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef struct packed {
    dq_pkg::status_t           status;
    logic [dq_pkg::WORD_W-1:0] front_value;
    logic [dq_pkg::WORD_W-1:0] back_value;
    logic [dq_pkg::OCC_W-1:0]  occupancy;
    logic                      is_empty;
    logic [dq_pkg::WORD_W-1:0] read_value;
  } deque_result_t;

  logic [dq_pkg::WORD_W-1:0] shadow_words [DEPTH];
  int unsigned               shadow_head;
  int unsigned               shadow_count;
  deque_result_t             awaited_results [$];
  int                        fail_total = 0;

  function automatic logic [SLOT_W-1:0] slot_at(int unsigned offset);
    return SLOT_W'((shadow_head + offset) % DEPTH);
  endfunction

  // Appends up to n copies at the back; 1 when all of them fitted.
  function automatic bit fill_tail(int unsigned n, logic [dq_pkg::WORD_W-1:0] word);
    int unsigned take;
    take = (n < DEPTH - shadow_count) ? n : DEPTH - shadow_count;
    for (int unsigned k = 0; k < take; k++) begin
      shadow_words[slot_at(shadow_count)] = word;
      shadow_count++;
    end
    return take == n;
  endfunction

  function automatic deque_result_t compute_deque_result(dq_pkg::op_t op,
                                                         logic [dq_pkg::WORD_W-1:0] word,
                                                         logic [dq_pkg::AMT_W-1:0] amount);
    deque_result_t r;
    r.status     = dq_pkg::ST_OK;
    r.read_value = dq_pkg::NONE_WORD;
    case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = dq_pkg::ST_OVERFLOW;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_words[SLOT_W'(shadow_head)] = word;
          shadow_count++;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (!fill_tail(1, word)) r.status = dq_pkg::ST_OVERFLOW;
      end
      dq_pkg::OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = dq_pkg::ST_UNDERFLOW;
        end else begin
          shadow_head = 32'(slot_at(1));
          shadow_count--;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (shadow_count == 0) r.status = dq_pkg::ST_UNDERFLOW;
        else shadow_count--;
      end
      dq_pkg::OP_READ: begin
        if (32'(amount) >= shadow_count) r.status = dq_pkg::ST_RANGE;
        else r.read_value = shadow_words[slot_at(32'(amount))];
      end
      dq_pkg::OP_CLEAR: begin
        shadow_count = 0;
        shadow_head  = 0;
      end
      dq_pkg::OP_RESIZE: begin
        if (32'(amount) < shadow_count) begin
          shadow_count = 32'(amount);
        end else if (32'(amount) > shadow_count) begin
          if (!fill_tail(32'(amount) - shadow_count, word)) r.status = dq_pkg::ST_OVERFLOW;
        end
      end
      default: begin
        if (!fill_tail(32'(amount), word)) r.status = dq_pkg::ST_OVERFLOW;
      end
    endcase
    if (shadow_count == 0) begin
      r.front_value = dq_pkg::NONE_WORD;
      r.back_value  = dq_pkg::NONE_WORD;
    end else begin
      r.front_value = shadow_words[slot_at(0)];
      r.back_value  = shadow_words[slot_at(shadow_count - 1)];
    end
    r.occupancy = shadow_count[dq_pkg::OCC_W-1:0];
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    deque_result_t plan;
    if (rst) begin
      shadow_head  = 0;
      shadow_count = 0;
      awaited_results.delete();
      mismatches      <= 0;
      outstanding     <= 0;
      predicted_count <= '0;
    end else begin
      // result side first: a result never belongs to a command of the same edge
      if (res.valid && res.ready) begin
        got.status      = dq_pkg::status_t'(res.status);
        got.front_value = res.front_value;
        got.back_value  = res.back_value;
        got.occupancy   = res.occupancy;
        got.is_empty    = res.is_empty;
        got.read_value  = res.read_value;
        if (awaited_results.size() == 0) begin
          if (fail_total < 10)
            $display("%0t: result beat with nothing pending: status=%0d occ=%0d",
                     $realtime, got.status, got.occupancy);
          fail_total++;
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (got.status !== want.status || got.front_value !== want.front_value ||
              got.back_value !== want.back_value || got.occupancy !== want.occupancy ||
              got.is_empty !== want.is_empty || got.read_value !== want.read_value) begin
            if (fail_total < 10) begin
              $display("%0t: exp status=%0d front=%0d back=%0d occ=%0d empty=%0d read=%0d",
                       $realtime, want.status, $signed(want.front_value),
                       $signed(want.back_value), want.occupancy, want.is_empty,
                       $signed(want.read_value));
              $display("%0t: got status=%0d front=%0d back=%0d occ=%0d empty=%0d read=%0d",
                       $realtime, got.status, $signed(got.front_value),
                       $signed(got.back_value), got.occupancy, got.is_empty,
                       $signed(got.read_value));
            end
            fail_total++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        plan = compute_deque_result(dq_pkg::op_t'(cmd.operation), cmd.value, cmd.amount);
        awaited_results.insert(awaited_results.size(), plan);
      end
      mismatches      <= fail_total;
      outstanding     <= awaited_results.size();
      predicted_count <= shadow_count[dq_pkg::OCC_W-1:0];
    end
  end

endmodule

>>> test/double_ended_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives command beats into the deque (directed corner cases, then random
// traffic that drifts between filling and draining), takes result beats
// with a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

  localparam int DEPTH        = 256;
  localparam int RANDOM_ITEMS = 1775;
  localparam int DRIFT_SPAN   = 150;    // items between changes of traffic drift
  localparam int LONG_HOLD    = 3000;   // receiver hold-off, in cycles

  // Traffic drift: which way the random mix pushes the occupancy.
  typedef enum int {
    DRIFT_GROW,
    DRIFT_MIXED,
    DRIFT_DRAIN
  } drift_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dq_cmd_if cmd_ch ();
  dq_res_if res_ch ();

  int                       mismatches;
  int                       outstanding;
  logic [dq_pkg::OCC_W-1:0] predicted_count;

  int     burst_left = 0;
  drift_t drift      = DRIFT_MIXED;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  double_ended_queue #(.DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  double_ended_queue_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd_ch),
    .res             (res_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .predicted_count (predicted_count)
  );

  // Offers one command beat and returns at the edge that accepts it.
  // Beats go out in bursts; between bursts valid drops for a random gap
  // (sometimes none, so back-to-back stretches occur too). valid stays
  // high across beats of one burst, so it is never lowered and raised
  // within one time step.
  task automatic send_command(input dq_pkg::op_t op,
                              input logic [dq_pkg::WORD_W-1:0] word,
                              input logic [dq_pkg::AMT_W-1:0] amount);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.value     <= word;
    cmd_ch.amount    <= amount;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Sender goes quiet until every predicted result has been taken.
  // The first edge lets the checker count the beat just accepted.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result receiver: stalls on a 32-bit pattern reloaded after each full
  // rotation (all ready, random, light or heavy stalls). After the 40th and the
  // 700th result it holds ready low for a long stretch so the block backs
  // up and stalls its command input while the sender keeps offering.
  initial begin
    logic [31:0] pattern;
    int          pattern_age;
    int          hold_left;
    int          taken;
    pattern     = '1;
    pattern_age = 0;
    hold_left   = 0;
    taken       = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        taken++;
        if (taken == 40 || taken == 700) hold_left = LONG_HOLD;
      end
      if (pattern_age == 0) begin
        pattern_age = 32;
        case ($urandom_range(0, 3))
          0:       pattern = '1;
          1:       pattern = $urandom;
          2:       pattern = $urandom | $urandom;
          default: pattern = $urandom & $urandom;
        endcase
      end
      pattern_age--;
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= pattern[0];
      end
      pattern = {pattern[0], pattern[31:1]};
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("double_ended_queue regression: fail");
    $finish;
  end

  initial begin
    dq_pkg::op_t               op;
    logic [dq_pkg::WORD_W-1:0] word;
    logic [dq_pkg::AMT_W-1:0]  amount;
    int                        pick;
    int                        occ;
    int                        w_push;
    int                        w_pop;
    int                        w_read;
    int                        w_clear;
    int                        w_resize;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= dq_pkg::OP_READ;
    cmd_ch.value     <= '0;
    cmd_ch.amount    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ---- directed corner cases ----
    send_command(dq_pkg::OP_POP_FRONT, 32'h0, 9'd0);            // underflow at front
    send_command(dq_pkg::OP_POP_BACK, 32'h0, 9'd0);             // underflow at back
    send_command(dq_pkg::OP_READ, 32'h0, 9'd0);                 // any read on empty: range
    send_command(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 9'd0);   // most negative word
    send_command(dq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 9'd0);    // most positive word
    send_command(dq_pkg::OP_READ, 32'h0, 9'd0);
    send_command(dq_pkg::OP_READ, 32'h0, 9'd1);
    send_command(dq_pkg::OP_READ, 32'h0, 9'd2);                 // one past the end
    send_command(dq_pkg::OP_READ, 32'h0, 9'd256);               // index DEPTH: past any slot
    send_command(dq_pkg::OP_APPEND, 32'h1357_9BDF, 9'd0);       // zero copies: no change
    send_command(dq_pkg::OP_RESIZE, 32'h2468_ACE0, 9'd2);       // resize to current size
    send_command(dq_pkg::OP_RESIZE, 32'h5555_5555, 9'd256);     // grow to exactly full
    send_command(dq_pkg::OP_PUSH_FRONT, 32'hDEAD_0001, 9'd0);   // full: overflow
    send_command(dq_pkg::OP_PUSH_BACK, 32'hDEAD_0002, 9'd0);    // full: overflow
    send_command(dq_pkg::OP_APPEND, 32'hDEAD_0003, 9'd3);       // full: nothing fits
    send_command(dq_pkg::OP_READ, 32'h0, 9'd255);               // last slot
    send_command(dq_pkg::OP_POP_FRONT, 32'h0, 9'd0);
    send_command(dq_pkg::OP_POP_BACK, 32'h0, 9'd0);
    send_command(dq_pkg::OP_APPEND, 32'hAAAA_AAAA, 9'd256);     // partial fill: overflow
    send_command(dq_pkg::OP_RESIZE, 32'hFFFF_FFFF, 9'd5);       // shrink from the back
    send_command(dq_pkg::OP_CLEAR, 32'h0, 9'd0);
    send_command(dq_pkg::OP_POP_BACK, 32'h0, 9'd0);             // empty again
    send_command(dq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 9'd0);
    send_command(dq_pkg::OP_RESIZE, 32'h1234_5678, 9'd3);       // grow by a fill word
    send_command(dq_pkg::OP_RESIZE, 32'h0, 9'd0);               // shrink to empty
    drain_results();

    // ---- random traffic ----
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % DRIFT_SPAN == 0) drift = drift_t'($urandom_range(0, 2));
      if (i == RANDOM_ITEMS / 2) drain_results();
      // occupancy as the checker last saw it; one beat stale at most,
      // which only shapes the mix
      occ = int'(predicted_count);
      case (drift)
        DRIFT_GROW: begin
          w_push = 35; w_pop = 10; w_read = 22; w_clear = 1; w_resize = 10;
        end
        DRIFT_DRAIN: begin
          w_push = 12; w_pop = 45; w_read = 22; w_clear = 3; w_resize = 12;
        end
        default: begin
          w_push = 25; w_pop = 25; w_read = 22; w_clear = 2; w_resize = 12;
        end
      endcase
      case ($urandom_range(0, 15))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7FFF_FFFF;
        2:       word = '1;
        3:       word = '0;
        default: word = $urandom;
      endcase
      amount = '0;
      pick   = $urandom_range(0, 99);
      if (pick < w_push) begin
        op = ($urandom_range(0, 1) != 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
      end else if (pick < w_push + w_pop) begin
        op = ($urandom_range(0, 1) != 0) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
      end else if (pick < w_push + w_pop + w_read) begin
        // mostly valid indexes, the rest past the end up to DEPTH
        op = dq_pkg::OP_READ;
        if (occ > 0 && $urandom_range(0, 4) != 0)
          amount = dq_pkg::AMT_W'($urandom_range(0, occ - 1));
        else
          amount = dq_pkg::AMT_W'($urandom_range(occ, DEPTH));
      end else if (pick < w_push + w_pop + w_read + w_clear) begin
        op = dq_pkg::OP_CLEAR;
      end else if (pick < w_push + w_pop + w_read + w_clear + w_resize) begin
        op = dq_pkg::OP_RESIZE;
        case ($urandom_range(0, 9))
          0:       amount = dq_pkg::AMT_W'(DEPTH);
          1:       amount = '0;
          2:       amount = dq_pkg::AMT_W'(occ);
          3:       amount = dq_pkg::AMT_W'($urandom_range(0, DEPTH));
          default: amount = dq_pkg::AMT_W'($urandom_range(occ > 8 ? occ - 8 : 0,
                                           occ < DEPTH - 8 ? occ + 8 : DEPTH));
        endcase
      end else begin
        op = dq_pkg::OP_APPEND;
        case ($urandom_range(0, 7))
          0:       amount = '0;
          1:       amount = dq_pkg::AMT_W'($urandom_range(0, DEPTH));
          2:       amount = dq_pkg::AMT_W'(DEPTH);
          default: amount = dq_pkg::AMT_W'($urandom_range(1, 12));
        endcase
      end
      send_command(op, word, amount);
    end

    // ---- wind down ----
    drain_results();
    repeat (DEPTH + 8) @(posedge clk);   // catch any stray result beat
    if (mismatches == 0 && outstanding == 0)
      $display("double_ended_queue regression: pass");
    else
      $display("double_ended_queue regression: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/dq_chain.sv
rtl/dq_seq.sv
rtl/double_ended_queue.sv
rtl/dq_checker.sv
test/double_ended_queue_checker.sv
test/double_ended_queue_test.sv
